### hw/rtl/amda_pkg.sv
// Shared types and constants for the multichannel audio downmix averager.
// No dependencies; every other file in hw/rtl but amda_stream_if imports this package.
package amda_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int FMT_W     = 2;
  localparam int CNT_CFG_W = 4;
  // Widest dividend the divider ever sees: 8-bit unsigned division of a
  // negative frame sum works on its 64-bit two's complement image.
  localparam int DIV_W     = 64;

  // Sample format codes
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S24 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [FMT_W-1:0]     FORMAT_RESET = FMT_S16;
  localparam logic [CNT_CFG_W-1:0] COUNT_RESET  = 4'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] channel_sample;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mono_sample;
    logic                last_output;
  } out_item_t;

  typedef struct packed {
    logic accept;    // add the incoming sample to the frame sum
    logic prep;      // load the divider from the frame sum, clear the sum
    logic step;      // one quotient bit
    logic load_out;  // move the quotient into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end; // incoming sample closes the frame
    logic div_last;  // divider is on its final step
  } dp_sts_t;

  function automatic logic [SAMPLE_W-1:0] format_mask(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] m;
    case (fmt)
      FMT_U8:  m = 32'h0000_00FF;
      FMT_S16: m = 32'h0000_FFFF;
      FMT_S24: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/amda_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload type is supplied per instance (in_item_t / out_item_t from amda_pkg).
interface amda_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/multichannel_audio_downmix_average.sv
// Multichannel downmix to mono by averaging. Interleaved channel samples arrive
// one request at a time and are summed; when channel_count samples (or a sample
// marked last) have arrived, the sum is divided by the number of samples in the
// frame and the quotient, cut to the format width, is sent out with the last flag.
// A frame-closing sample steps the block through its prep, divide and finish
// states; no sample is taken until it is idle again. The bit-serial divider makes
// one quotient bit per cycle, over DIV_W bits instead of SUM_W for an 8-bit frame
// whose sum went negative through a mid-frame format change. A finished result
// sits in the output register while the next frame's samples are taken.
// Depends on amda_pkg, amda_stream_if, amda_regs, amda_ctrl, amda_dp.
module multichannel_audio_downmix_average #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst,
  amda_stream_if.sink   samples,
  amda_stream_if.source mono,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import amda_pkg::*;

  logic [FMT_W-1:0]     sample_format;
  logic [CNT_CFG_W-1:0] channel_count;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  in_item_t             in_item;
  out_item_t            out_item;

  assign in_item      = samples.payload;
  assign mono.payload = out_item;

  amda_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sample_format (sample_format),
    .channel_count (channel_count)
  );

  amda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (mono.valid),
    .out_ready (mono.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  amda_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .item          (in_item),
    .sample_format (sample_format),
    .channel_count (channel_count),
    .out_item      (out_item)
  );

endmodule

### hw/rtl/amda_regs.sv
// APB-style configuration registers: sample format and channel count.
// Depends on amda_pkg.
module amda_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [amda_pkg::FMT_W-1:0]     sample_format,
  output logic [amda_pkg::CNT_CFG_W-1:0] channel_count
);
  import amda_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FORMAT_RESET;
      channel_count <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FORMAT: sample_format <= pwdata[FMT_W-1:0];
        REG_COUNT:  channel_count <= pwdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_FORMAT: prdata = {{(32-FMT_W){1'b0}}, sample_format};
        REG_COUNT:  prdata = {{(32-CNT_CFG_W){1'b0}}, channel_count};
        default:    prdata = '0;
      endcase
    end
  end

endmodule

### hw/rtl/amda_dp.sv
// Datapath: sample decode, frame accumulator, bit-serial divider, output register.
// Depends on amda_pkg; driven by amda_ctrl through dp_cmd_t / dp_sts_t.
module amda_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  amda_pkg::dp_cmd_t              cmd,
  output amda_pkg::dp_sts_t              sts,
  input  amda_pkg::in_item_t             item,
  input  logic [amda_pkg::FMT_W-1:0]     sample_format,
  input  logic [amda_pkg::CNT_CFG_W-1:0] channel_count,
  output amda_pkg::out_item_t            out_item
);
  import amda_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = SAMPLE_W + 1 + $clog2(MAX_CHANNELS);
  localparam int ITER_W = $clog2(DIV_W + 1);
  localparam logic [4:0] MAX5 = 5'(MAX_CHANNELS);

  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    dec;
  logic [SUM_W-1:0]    mag;
  logic [CNT_W-1:0]    chan_index;
  logic [CNT_W-1:0]    received;
  logic [4:0]          received5;
  logic [4:0]          eff5;
  logic [CNT_W-1:0]    divisor;
  logic                last_hold;
  logic [FMT_W-1:0]    fmt_hold;
  logic                negate;
  logic [DIV_W-1:0]    dq;
  logic [CNT_W-1:0]    rem;
  logic [ITER_W-1:0]   iter;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                ge;
  logic                sum_neg;
  logic [SAMPLE_W-1:0] q_low;
  logic [SAMPLE_W-1:0] q_res;

  // Sign- or zero-extend the sample per format
  always_comb begin
    case (sample_format)
      FMT_U8:  dec = {{(SUM_W-8){1'b0}}, item.channel_sample[7:0]};
      FMT_S16: dec = {{(SUM_W-16){item.channel_sample[15]}}, item.channel_sample[15:0]};
      FMT_S24: dec = {{(SUM_W-24){item.channel_sample[23]}}, item.channel_sample[23:0]};
      default: dec = {{(SUM_W-32){item.channel_sample[31]}}, item.channel_sample[31:0]};
    endcase
  end

  // Effective channel count: zero acts as one, clamp at MAX_CHANNELS
  always_comb begin
    if (channel_count == '0) begin
      eff5 = 5'd1;
    end else if ({1'b0, channel_count} > MAX5) begin
      eff5 = MAX5;
    end else begin
      eff5 = {1'b0, channel_count};
    end
  end

  assign received      = chan_index + CNT_W'(1);
  assign received5     = 5'(chan_index) + 5'd1;
  assign sts.frame_end = (received5 >= eff5) || item.last_sample;
  assign sts.div_last  = (iter == ITER_W'(1));

  assign sum_neg = sum[SUM_W-1];
  assign mag     = sum_neg ? (~sum + SUM_W'(1)) : sum;

  assign trial = {rem, dq[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  assign q_low = dq[SAMPLE_W-1:0];
  assign q_res = negate ? (~q_low + SAMPLE_W'(1)) : q_low;

  // Frame accumulator, channel position and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      chan_index <= '0;
      iter       <= '0;
    end else begin
      if (cmd.accept) begin
        sum        <= sum + dec;
        chan_index <= sts.frame_end ? '0 : received;
      end else if (cmd.prep) begin
        sum <= '0;
      end
      if (cmd.prep) begin
        iter <= (sample_format == FMT_U8 && sum_neg) ? ITER_W'(DIV_W) : ITER_W'(SUM_W);
      end else if (cmd.step) begin
        iter <= iter - ITER_W'(1);
      end
    end
  end

  // Divider operands and output register
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.frame_end) begin
      divisor   <= received;
      last_hold <= item.last_sample;
    end
    if (cmd.prep) begin
      fmt_hold <= sample_format;
      rem      <= '0;
      if (sample_format == FMT_U8 && sum_neg) begin
        // unsigned view of the 64-bit two's complement sum
        dq     <= {{(DIV_W-SUM_W){1'b1}}, sum};
        negate <= 1'b0;
      end else begin
        // left-align the magnitude so SUM_W steps cover it
        dq     <= {mag, {(DIV_W-SUM_W){1'b0}}};
        negate <= sum_neg;
      end
    end else if (cmd.step) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
    if (cmd.load_out) begin
      out_item.mono_sample <= q_res & format_mask(fmt_hold);
      out_item.last_output <= last_hold;
    end
  end

endmodule

### hw/rtl/amda_ctrl.sv
// Controller: input handshake, divide sequencing, output valid flag.
// Depends on amda_pkg; commands amda_dp.
module amda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  amda_pkg::dp_sts_t sts,
  output amda_pkg::dp_cmd_t cmd
);
  import amda_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready     = (state == S_IDLE);
  assign out_free     = !out_valid || out_ready;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.prep     = (state == S_PREP);
  assign cmd.step     = (state == S_DIV);
  assign cmd.load_out = (state == S_FIN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.accept && sts.frame_end) state_next = S_PREP;
      S_PREP: state_next = S_DIV;
      S_DIV:  if (sts.div_last) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### test/tb_multichannel_audio_downmix_average.sv
// Self-checking testbench for multichannel_audio_downmix_average.
// Drives channel samples and register writes, checks readback and every mono result.
// Depends on amda_pkg, amda_stream_if and the RTL under hw/rtl.
module tb_multichannel_audio_downmix_average;
  timeunit 1ns;
  timeprecision 1ps;

  import amda_pkg::*;

  localparam int MAX_CH       = 8;
  localparam int SAMPLE_TOTAL = 1550;
  localparam int SETTLE       = 90;    // covers the longest frame
  localparam int QUIET_LIMIT  = 3000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        reg_sel;
    logic [31:0] data;
    logic        last;
    logic        typed;
    logic [31:0] want;
    logic        want_last;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 41;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  amda_stream_if #(.payload_t(in_item_t))  samples_if ();
  amda_stream_if #(.payload_t(out_item_t)) mono_if ();

  multichannel_audio_downmix_average #(.MAX_CHANNELS(MAX_CH)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .mono    (mono_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state and register shadow
  logic [FMT_W-1:0]     cur_format = FORMAT_RESET;
  logic [CNT_CFG_W-1:0] cur_count  = COUNT_RESET;
  longint               frame_sum  = 0;
  int unsigned          frame_fill = 0;

  out_item_t pending_mono [$];
  int  errors          = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  burst_left      = 0;
  int  quiet_cycles    = 0;
  bit  need_settle     = 0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    // 16-bit after reset, two channels
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_7FFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hA5A5_7FFF, 1'b0, 1'b1, 32'h0000_7FFF, 1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hFFFF_8000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_8000, 1'b0, 1'b1, 32'h0000_8000, 1'b0},
    // -1 / 2 truncates toward zero
    '{ROW_SAMPLE, REG_FORMAT, 32'h1234_0003, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_FFFC, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    // 8-bit unsigned, frame flushed early by the last mark
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_U8),   1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_COUNT,  32'd8,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_00FF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_00AA, 1'b1},
    // zero channel count acts as one
    '{ROW_WRITE,  REG_COUNT,  32'd0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hABCD_EF80, 1'b0, 1'b1, 32'h0000_0080, 1'b0},
    // count above the maximum saturates to eight, 32-bit minimum
    '{ROW_WRITE,  REG_COUNT,  32'd15,        1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_S32),  1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    // 24-bit, one channel
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_S24),  1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_COUNT,  32'd1,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h00FF_FFFF, 1'b0, 1'b1, 32'h00FF_FFFF, 1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0080_0000, 1'b1, 1'b1, 32'h0080_0000, 1'b1},
    // format switched and count lowered mid-frame: negative sum, unsigned divide
    '{ROW_WRITE,  REG_COUNT,  32'd3,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_S16),  1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_U8),   1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_COUNT,  32'd2,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hFFFF_FF00, 1'b0, 1'b0, 32'h0,         1'b0},
    // 32-bit maximum
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_S32),  1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // single 8-bit extremes
    '{ROW_WRITE,  REG_FORMAT, 32'(FMT_U8),   1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  REG_COUNT,  32'd1,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'h0000_00FF, 1'b0, 1'b1, 32'h0000_00FF, 1'b0},
    '{ROW_SAMPLE, REG_FORMAT, 32'hFFFF_FF00, 1'b1, 1'b1, 32'h0000_0000, 1'b1}
  };

  function automatic logic [31:0] width_mask(input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_U8:  return 32'h0000_00FF;
      FMT_S16: return 32'h0000_FFFF;
      FMT_S24: return 32'h00FF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic longint decode_raw(input logic [31:0] raw, input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_U8:  return longint'({24'd0, raw[7:0]});
      FMT_S16: return longint'($signed(raw[15:0]));
      FMT_S24: return longint'($signed(raw[23:0]));
      default: return longint'($signed(raw));
    endcase
  endfunction

  // Add one sample to the frame; return 1 with the mono result when it closes.
  function automatic bit downmix_predict(input logic [31:0] raw, input logic mark,
                                         output out_item_t res);
    int unsigned received;
    int unsigned frame_len;
    longint unsigned quotient;
    res = '0;
    frame_sum += decode_raw(raw, cur_format);
    received = frame_fill + 1;
    frame_len = (cur_count == 0) ? 1 : ((cur_count > MAX_CH) ? MAX_CH : cur_count);
    if (received < frame_len && !mark) begin
      frame_fill = received;
      return 1'b0;
    end
    if (cur_format == FMT_U8) begin
      quotient = $unsigned(frame_sum) / 64'(received);
    end else begin
      quotient = $unsigned(frame_sum / longint'(received));
    end
    res.mono_sample = quotient[31:0] & width_mask(cur_format);
    res.last_output = mark;
    frame_sum = 0;
    frame_fill = 0;
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one request and hold it until taken, then pace the next burst.
  task automatic send_sample(input logic [31:0] raw, input logic mark, input logic typed,
                             input out_item_t want);
    in_item_t  req;
    out_item_t res;
    int        gap;
    req.channel_sample = raw;
    req.last_sample = mark;
    samples_if.valid <= 1'b1;
    samples_if.payload <= req;
    do @(posedge clk); while (!samples_if.ready);
    samples_sent++;
    need_settle = 1;
    if (downmix_predict(raw, mark, res) || typed)
      pending_mono.push_back(typed ? want : res);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid, drain expected results and let any divide still running finish.
  task automatic quiesce();
    samples_if.valid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    if (need_settle) repeat (SETTLE) @(posedge clk);
    else @(posedge clk);
    need_settle = 0;
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] field_mask;
    logic [31:0] got;
    field_mask = (sel == REG_FORMAT) ? 32'h3 : 32'hF;
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_FORMAT) cur_format = value[FMT_W-1:0];
    else cur_count = value[CNT_CFG_W-1:0];
    reg_writes++;
    // read the register back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & field_mask) != (value & field_mask)) begin
      $error("register %0d readback: expected %h, got %h", sel, value & field_mask,
             got & field_mask);
      errors++;
    end
  endtask

  // Receiver pacing: runs of always-ready, coin-flip ready and sparse ready
  initial begin
    int rx_mode;
    int rx_left;
    rx_mode = 0;
    rx_left = 0;
    mono_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 80);
      end
      rx_left--;
      case (rx_mode)
        0:       mono_if.ready <= 1'b1;
        1:       mono_if.ready <= 1'($urandom_range(0, 1));
        default: mono_if.ready <= (rx_left % 6 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_mono
    out_item_t want;
    if (!rst && mono_if.valid && mono_if.ready) begin
      if (pending_mono.size() == 0) begin
        $error("unexpected mono result %h last %b", mono_if.payload.mono_sample,
               mono_if.payload.last_output);
        errors++;
      end else begin
        want = pending_mono.pop_front();
        results_checked++;
        if (mono_if.payload.mono_sample !== want.mono_sample) begin
          $error("mono_sample: expected %h, got %h", want.mono_sample,
                 mono_if.payload.mono_sample);
          errors++;
        end
        if (mono_if.payload.last_output !== want.last_output) begin
          $error("last_output: expected %b, got %b", want.last_output,
                 mono_if.payload.last_output);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (mono_if.valid && mono_if.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** multichannel_audio_downmix_average: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          phase;
    int          run_len;
    int          kind;
    logic [31:0] raw;
    logic [31:0] m;
    logic [1:0]  fmt_pick;
    logic [3:0]  cnt_pick;
    out_item_t   want;
    logic [3:0]  early_counts [8];
    early_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd7};
    rst <= 1'b1;
    samples_if.valid <= 1'b0;
    samples_if.payload <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        write_reg(directed[i].reg_sel, directed[i].data);
      end else begin
        want.mono_sample = directed[i].want;
        want.last_output = directed[i].want_last;
        send_sample(directed[i].data, directed[i].last, directed[i].typed, want);
      end
    end

    // Random phases; a phase may end mid-frame so the next write lands inside it
    phase = 0;
    want = '0;
    while (samples_sent < SAMPLE_TOTAL) begin
      if (phase < 8) begin
        write_reg(REG_FORMAT, 32'(phase % 4));
        write_reg(REG_COUNT, 32'(early_counts[phase]));
      end else begin
        fmt_pick = 2'($urandom_range(0, 3));
        cnt_pick = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
        if ($urandom_range(0, 3) != 0) write_reg(REG_FORMAT, 32'(fmt_pick));
        if ($urandom_range(0, 3) != 0) write_reg(REG_COUNT, 32'(cnt_pick));
      end
      run_len = $urandom_range(10, 60);
      repeat (run_len) begin
        raw = $urandom;
        m = width_mask(cur_format);
        kind = $urandom_range(0, 9);
        case (kind)
          0: raw = (raw & ~m) | (m >> 1);        // largest positive in signed formats
          1: raw = raw | m;                      // all ones
          2: raw = (raw & ~m) | ((m >> 1) + 1);  // most negative in signed formats
          3: raw = raw & ~m;                     // zero
          default: ;
        endcase
        send_sample(raw, 1'($urandom_range(0, 19) == 0), 1'b0, want);
      end
      phase++;
    end

    samples_if.valid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d channel samples over %0d phases with %0d register writes,",
             samples_sent, phase, reg_writes);
    $display("checked %0d mono results across all four formats and counts 0..15.",
             results_checked);
    if (errors == 0) begin
      $display("** multichannel_audio_downmix_average: PASSED **");
    end else begin
      $display("** multichannel_audio_downmix_average: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/amda_pkg.sv
hw/rtl/amda_stream_if.sv
hw/rtl/amda_regs.sv
hw/rtl/amda_dp.sv
hw/rtl/amda_ctrl.sv
hw/rtl/multichannel_audio_downmix_average.sv
test/tb_multichannel_audio_downmix_average.sv
